>>> src/meh_pkg.sv
// Shared widths, register codes and CORDIC angle table for the magnetometer heading block.
package meh_pkg;

  localparam int MAG_W        = 24;
  localparam int CFG_DATA_W   = 24;
  localparam int CFG_IDX_W    = 3;
  localparam int TRIG_W       = 16;
  localparam int INV_W        = 16;
  localparam int HEAD_W       = 16;

  // datapath widths
  localparam int D_W  = MAG_W + 1;          // centered sample
  localparam int P1_W = D_W + TRIG_W;       // first rotation products
  localparam int R_W  = P1_W + 1;           // rotated, Q.15
  localparam int U_W  = R_W - 15;           // rounded to counts
  localparam int Q_W  = U_W + INV_W + 1;    // scaled product
  localparam int W_W  = Q_W - 16;           // scaled, rounded
  localparam int M_W  = W_W + TRIG_W;       // back-rotation products
  localparam int V_W  = M_W + 1;            // back-rotated vector
  localparam int X_W  = V_W + 2;            // CORDIC growth headroom

  localparam int ANGLE_BITS_DEF   = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_LEN         = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X       = 3'd0,
    REG_CENTER_Y       = 3'd1,
    REG_COS_ANGLE      = 3'd2,
    REG_SIN_ANGLE      = 3'd3,
    REG_INV_MAJOR      = 3'd4,
    REG_INV_MINOR      = 3'd5,
    REG_HEADING_OFFSET = 3'd6
  } cfg_reg_t;

  // atan(2^-i), 2^32 per turn
  localparam logic [31:0] ATAN_TURN32 [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // table entry rounded half up to 2^abits per turn
  function automatic logic [31:0] atan_step(int unsigned idx, int unsigned abits);
    logic [32:0] t;
    t = {1'b0, ATAN_TURN32[idx % ATAN_LEN]} + (33'd1 << (31 - abits));
    return 32'(t >> (32 - abits));
  endfunction

endpackage

>>> src/meh_sample_if.sv
// Input channel: one raw X/Y magnetometer sample per item.
interface meh_sample_if;
  logic                             valid;
  logic                             ready;
  logic signed [meh_pkg::MAG_W-1:0] mag_x;
  logic signed [meh_pkg::MAG_W-1:0] mag_y;

  modport source (output valid, output mag_x, output mag_y, input ready);
  modport sink   (input valid, input mag_x, input mag_y, output ready);
endinterface

>>> src/meh_heading_if.sv
// Output channel: one compensated heading per item.
interface meh_heading_if;
  logic                              valid;
  logic                              ready;
  logic signed [meh_pkg::HEAD_W-1:0] heading;

  modport source (output valid, output heading, input ready);
  modport sink   (input valid, input heading, output ready);
endinterface

>>> src/magnetometer_ellipse_heading_top.sv
// Soft-iron ellipse compensation and pipelined CORDIC atan2 heading.
//
//  channel   dir  payload                      handshake
//  sample    in   mag_x[23:0], mag_y[23:0]     valid/ready
//  result    out  heading[15:0]                valid/ready
//  cfg       in   cfg_index[2:0], cfg_data     cfg_write
//
// One item per cycle sustained while the output is taken; the stages are
// 7 compensation stages, one CORDIC stage per step and one output stage.
// rst is synchronous and empties the pipeline; configuration registers return to defaults.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles close up under a stall and the input keeps taking items while the
// output register holds an untaken result, until every stage is full.
module magnetometer_ellipse_heading_top #(
  parameter int ANGLE_BITS   = meh_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STEPS = meh_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  meh_sample_if.sink                         sample,
  meh_heading_if.source                      result,
  input  logic                               cfg_write,
  input  logic [meh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [meh_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int NST = 8 + CORDIC_STEPS;
  localparam int XW  = meh_pkg::X_W;

  // configuration registers
  logic signed [meh_pkg::MAG_W-1:0]  center_x, center_y;
  logic signed [meh_pkg::TRIG_W-1:0] cos_angle, sin_angle;
  logic        [meh_pkg::INV_W-1:0]  inv_major, inv_minor;
  logic signed [meh_pkg::HEAD_W-1:0] heading_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x       <= '0;
      center_y       <= '0;
      cos_angle      <= 16'sd32767;
      sin_angle      <= '0;
      inv_major      <= 16'hFFFF;
      inv_minor      <= 16'hFFFF;
      heading_offset <= '0;
    end else if (cfg_write) begin
      case (meh_pkg::cfg_reg_t'(cfg_index))
        meh_pkg::REG_CENTER_X:       center_x       <= cfg_data;
        meh_pkg::REG_CENTER_Y:       center_y       <= cfg_data;
        meh_pkg::REG_COS_ANGLE:      cos_angle      <= cfg_data[15:0];
        meh_pkg::REG_SIN_ANGLE:      sin_angle      <= cfg_data[15:0];
        meh_pkg::REG_INV_MAJOR:      inv_major      <= cfg_data[15:0];
        meh_pkg::REG_INV_MINOR:      inv_minor      <= cfg_data[15:0];
        meh_pkg::REG_HEADING_OFFSET: heading_offset <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // stage flow control
  logic [NST-1:0] v;
  logic [NST-1:0] vin;
  logic [NST:0]   en;
  logic [NST-1:0] ld;

  assign vin     = {v[NST-2:0], sample.valid};
  assign en[NST] = result.ready;

  genvar g;
  generate
    for (g = 0; g < NST; g++) begin : g_flow
      assign en[g] = !v[g] || en[g+1];
      assign ld[g] = en[g] && vin[g];
    end
  endgenerate

  assign sample.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (en[k]) begin
          v[k] <= vin[k];
        end
      end
    end
  end

  // S1: remove center
  logic signed [meh_pkg::D_W-1:0] dx1, dy1;
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      dx1 <= meh_pkg::D_W'(sample.mag_x) - meh_pkg::D_W'(center_x);
      dy1 <= meh_pkg::D_W'(sample.mag_y) - meh_pkg::D_W'(center_y);
    end
  end

  // S2: rotation products
  logic signed [meh_pkg::P1_W-1:0] p_cx, p_sy, p_sx, p_cy;
  always_ff @(posedge clk) begin
    if (ld[1]) begin
      p_cx <= meh_pkg::P1_W'(cos_angle) * meh_pkg::P1_W'(dx1);
      p_sy <= meh_pkg::P1_W'(sin_angle) * meh_pkg::P1_W'(dy1);
      p_sx <= meh_pkg::P1_W'(sin_angle) * meh_pkg::P1_W'(dx1);
      p_cy <= meh_pkg::P1_W'(cos_angle) * meh_pkg::P1_W'(dy1);
    end
  end

  // S3: sum and round Q.15 back to counts
  logic signed [meh_pkg::R_W-1:0] rnd_x, rnd_y;
  logic signed [meh_pkg::U_W-1:0] ux, uy;
  assign rnd_x = meh_pkg::R_W'(p_cx) - meh_pkg::R_W'(p_sy) + meh_pkg::R_W'(16384);
  assign rnd_y = meh_pkg::R_W'(p_sx) + meh_pkg::R_W'(p_cy) + meh_pkg::R_W'(16384);
  always_ff @(posedge clk) begin
    if (ld[2]) begin
      ux <= rnd_x[meh_pkg::R_W-1:15];
      uy <= rnd_y[meh_pkg::R_W-1:15];
    end
  end

  // S4: axis scaling products
  logic signed [meh_pkg::Q_W-1:0] q_x, q_y;
  always_ff @(posedge clk) begin
    if (ld[3]) begin
      q_x <= meh_pkg::Q_W'(ux) * $signed(meh_pkg::Q_W'(inv_major));
      q_y <= meh_pkg::Q_W'(uy) * $signed(meh_pkg::Q_W'(inv_minor));
    end
  end

  // S5: round Q.16
  logic signed [meh_pkg::Q_W-1:0] qr_x, qr_y;
  logic signed [meh_pkg::W_W-1:0] wx, wy;
  assign qr_x = q_x + meh_pkg::Q_W'(32768);
  assign qr_y = q_y + meh_pkg::Q_W'(32768);
  always_ff @(posedge clk) begin
    if (ld[4]) begin
      wx <= qr_x[meh_pkg::Q_W-1:16];
      wy <= qr_y[meh_pkg::Q_W-1:16];
    end
  end

  // S6: inverse rotation products
  logic signed [meh_pkg::M_W-1:0] m_cx, m_sy, m_cy, m_sx;
  always_ff @(posedge clk) begin
    if (ld[5]) begin
      m_cx <= meh_pkg::M_W'(cos_angle) * meh_pkg::M_W'(wx);
      m_sy <= meh_pkg::M_W'(sin_angle) * meh_pkg::M_W'(wy);
      m_cy <= meh_pkg::M_W'(cos_angle) * meh_pkg::M_W'(wy);
      m_sx <= meh_pkg::M_W'(sin_angle) * meh_pkg::M_W'(wx);
    end
  end

  // S7: sum, fold left half plane to the right, flag the zero vector
  logic signed [meh_pkg::V_W-1:0] vx, vy;
  assign vx = meh_pkg::V_W'(m_cx) + meh_pkg::V_W'(m_sy);
  assign vy = meh_pkg::V_W'(m_cy) - meh_pkg::V_W'(m_sx);

  logic signed [XW-1:0]         cx   [CORDIC_STEPS+1];
  logic signed [XW-1:0]         cy   [CORDIC_STEPS+1];
  logic        [ANGLE_BITS-1:0] cacc [CORDIC_STEPS+1];
  logic                         czero[CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    if (ld[6]) begin
      if (vx < 0) begin
        cx[0]   <= -XW'(vx);
        cy[0]   <= -XW'(vy);
        cacc[0] <= ANGLE_BITS'(1) << (ANGLE_BITS - 1);
      end else begin
        cx[0]   <= XW'(vx);
        cy[0]   <= XW'(vy);
        cacc[0] <= '0;
      end
      czero[0] <= (vx == 0) && (vy == 0);
    end
  end

  // vectoring CORDIC, one step per stage
  generate
    for (g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
      logic [31:0]           step_full;
      logic [ANGLE_BITS-1:0] step;
      logic signed [XW-1:0]  xs, ys;
      assign step_full = meh_pkg::atan_step(g, ANGLE_BITS);
      assign step      = step_full[ANGLE_BITS-1:0];
      assign xs        = cx[g] >>> g;
      assign ys        = cy[g] >>> g;
      always_ff @(posedge clk) begin
        if (ld[7+g]) begin
          if (!cy[g][XW-1]) begin
            cx[g+1]   <= cx[g] + ys;
            cy[g+1]   <= cy[g] - xs;
            cacc[g+1] <= cacc[g] + step;
          end else begin
            cx[g+1]   <= cx[g] - ys;
            cy[g+1]   <= cy[g] + xs;
            cacc[g+1] <= cacc[g] - step;
          end
          czero[g+1] <= czero[g];
        end
      end
    end
  endgenerate

  // output stage: rescale to 16-bit turn, add offset
  logic [ANGLE_BITS-1:0]       acc_f;
  logic [meh_pkg::HEAD_W-1:0]  h16;
  assign acc_f = czero[CORDIC_STEPS] ? '0 : cacc[CORDIC_STEPS];

  generate
    if (ANGLE_BITS > meh_pkg::HEAD_W) begin : g_down
      localparam int DN = ANGLE_BITS - meh_pkg::HEAD_W;
      logic [ANGLE_BITS-1:0] acc_r;
      assign acc_r = acc_f + (ANGLE_BITS'(1) << (DN - 1));
      assign h16   = acc_r[ANGLE_BITS-1:DN];
    end else begin : g_up
      assign h16 = meh_pkg::HEAD_W'(acc_f) << (meh_pkg::HEAD_W - ANGLE_BITS);
    end
  endgenerate

  logic signed [meh_pkg::HEAD_W-1:0] heading_q;
  always_ff @(posedge clk) begin
    if (ld[NST-1]) begin
      heading_q <= h16 + heading_offset;
    end
  end

  assign result.valid   = v[NST-1];
  assign result.heading = heading_q;

  // the input side only stalls behind an untaken result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !sample.ready |-> (result.valid && !result.ready))
    else $error("input stalled without a blocked result");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> v[0])
    else $error("accepted item did not enter the first stage");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result.valid)
    else $error("result valid right after reset");

  a_zero_heading: assert property (@(posedge clk) disable iff (rst)
    (ld[NST-1] && czero[CORDIC_STEPS]) |=> (heading_q == $past(heading_offset)))
    else $error("zero vector heading differs from offset");

endmodule
